// ----- hw/rtl/wss_pkg.sv -----
// Shared types and constants for the windowed signal statistics block.
package wss_pkg;

  localparam int MaxWindowDefault   = 1024;
  localparam int SampleWidthDefault = 16;
  localparam int ModeWidth          = 2;
  localparam int LenWidth           = 11;
  localparam int CfgIndexWidth      = 1;
  localparam logic [LenWidth-1:0] LenReset = LenWidth'(1024);

  typedef enum logic [ModeWidth-1:0] {
    MODE_VALUE = 2'd0,
    MODE_DEV   = 2'd1,
    MODE_MEAN  = 2'd2,
    MODE_ALT   = 2'd3
  } mode_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_MODE   = 1'b0,
    REG_LENGTH = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_START,
    ST_MEAN_RE,
    ST_MEAN_IM,
    ST_DEV_READ,
    ST_DEV_WAIT,
    ST_DEV_RE,
    ST_DEV_IM,
    ST_DEV_DIV,
    ST_MAG_SQ_RE,
    ST_MAG_SQ_IM,
    ST_SQRT,
    ST_DONE
  } state_t;

  // Start/busy handshake between the sequencer and a multicycle unit.
  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;

endpackage

// ----- hw/rtl/windowed_signal_statistics.sv -----
// Top level: windowed mean magnitude, deviation and last-value probe.
// A sample that does not close a window leaves in_ready high, so such samples go in one per cycle.
// Closing sample, value or alt mode: result next cycle, input ready again after its transfer.
// Mean mode: both window sums are divided by N on the shared divider (one bit a cycle), the
// two means squared and summed, and the square root taken. Deviation mode instead sums the
// squared deviations of the N stored samples from the mean, divides once more and roots that.
// Synchronous active-high reset clears counters, sums, registers (mode 0, length 1024); no clearing pass.
module windowed_signal_statistics
  import wss_pkg::*;
#(
  parameter int MAX_WINDOW   = MaxWindowDefault,
  parameter int SAMPLE_WIDTH = SampleWidthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wss_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [wss_pkg::LenWidth-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] value_re,
  output logic signed [SAMPLE_WIDTH-1:0] value_im
);
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CW    = $clog2(MAX_WINDOW + 1);
  localparam int LW    = (CW > LenWidth) ? CW : LenWidth;
  localparam int SW    = SAMPLE_WIDTH + CW + 1;   // signed sum width
  localparam int DW    = SAMPLE_WIDTH + 2;        // difference width
  localparam int QW    = 2 * DW + CW + 2;         // accumulator width before rounding up to even
  localparam int AccW  = QW + (QW % 2);
  localparam int RW    = AccW / 2;
  localparam logic [SAMPLE_WIDTH-1:0] SatMax = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

  logic [ModeWidth-1:0] mode;
  logic [LenWidth-1:0]  window_length;
  logic [CW-1:0]        fill_count;
  logic signed [SW-1:0] sum_real, sum_imag;
  logic signed [SW-1:0] mean_re, mean_im;
  logic [AccW-1:0]      acc;
  logic [AW-1:0]        rd_idx;
  logic [CW-1:0]        n;
  state_t               state, state_next;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [2*SAMPLE_WIDTH-1:0] ram_rdata;

  // Shared multiplier operand and product register.
  logic signed [DW-1:0]   mul_a;
  logic [2*DW-1:0]        sq;
  logic [DW-1:0]          mul_abs;

  logic               div_start, div_busy;
  logic               sqrt_start, sqrt_busy;
  logic               div_neg;
  logic [AccW-1:0]    div_num;
  logic [AccW-1:0]    div_quot;
  logic [RW-1:0]      root;

  logic [CW-1:0]      len_eff;
  logic [CW-1:0]      fill_inc;
  logic               in_xfer, out_xfer, closing;
  logic               acc_pending;
  logic               quot_pending;

  always_comb begin
    if (window_length == '0) begin
      len_eff = CW'(1);
    end else if (LW'(window_length) > LW'(MAX_WINDOW)) begin
      len_eff = CW'(MAX_WINDOW);
    end else begin
      len_eff = CW'(window_length);
    end
  end

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign fill_inc = (fill_count < CW'(MAX_WINDOW)) ? fill_count + CW'(1) : fill_count;
  assign closing  = fill_inc >= len_eff;
  assign in_ready = (state == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ModeWidth'(MODE_VALUE);
      window_length <= LenReset;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_MODE:   mode <= cfg_data[ModeWidth-1:0];
        REG_LENGTH: window_length <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign ram_we   = in_xfer && (fill_count < CW'(MAX_WINDOW));
  assign ram_addr = in_xfer ? fill_count[AW-1:0] : rd_idx;

  wss_ram #(.Width(2 * SAMPLE_WIDTH), .Depth(MAX_WINDOW)) u_store (
    .clk, .we(ram_we), .addr(ram_addr), .wdata({sample_re, sample_im}), .rdata(ram_rdata)
  );

  always_comb begin
    case (state)
      ST_DEV_RE:    mul_a = DW'($signed(ram_rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])) - DW'(mean_re);
      ST_DEV_IM:    mul_a = DW'($signed(ram_rdata[SAMPLE_WIDTH-1:0])) - DW'(mean_im);
      ST_MAG_SQ_RE: mul_a = DW'(mean_re);
      ST_MAG_SQ_IM: mul_a = DW'(mean_im);
      default:      mul_a = '0;
    endcase
    mul_abs = mul_a[DW-1] ? DW'(-mul_a) : DW'(mul_a);
  end

  wss_divider #(.NumWidth(AccW), .DenWidth(CW)) u_div (
    .clk, .rst, .start(div_start), .num_neg(div_neg), .num_mag(div_num),
    .den(n), .busy(div_busy), .quot(div_quot)
  );

  wss_sqrt #(.InWidth(AccW)) u_sqrt (
    .clk, .rst, .start(sqrt_start), .radicand(acc), .busy(sqrt_busy), .root(root)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    div_neg    = 1'b0;
    div_num    = acc;
    case (state)
      ST_IDLE: begin
        if (in_xfer && closing && mode != MODE_VALUE && mode != MODE_ALT) begin
          state_next = ST_MEAN_START;
        end
      end
      // The window sums were copied into mean_re and mean_im at the closing transfer.
      ST_MEAN_START: begin
        div_start = 1'b1;
        div_neg = mean_re[SW-1];
        div_num = AccW'(mean_re[SW-1] ? -mean_re : mean_re);
        state_next = ST_MEAN_RE;
      end
      ST_MEAN_RE: begin
        if (!div_busy) begin
          div_start = 1'b1;
          div_neg = mean_im[SW-1];
          div_num = AccW'(mean_im[SW-1] ? -mean_im : mean_im);
          state_next = ST_MEAN_IM;
        end
      end
      ST_MEAN_IM: begin
        if (!div_busy) begin
          state_next = (mode == MODE_DEV) ? ST_DEV_READ : ST_MAG_SQ_RE;
        end
      end
      ST_DEV_READ: state_next = ST_DEV_WAIT;
      ST_DEV_WAIT: state_next = ST_DEV_RE;
      ST_DEV_RE:   state_next = ST_DEV_IM;
      ST_DEV_IM: begin
        state_next = (CW'(rd_idx) + CW'(1) >= n) ? ST_DEV_DIV : ST_DEV_READ;
      end
      ST_DEV_DIV: begin
        // Wait for the last product to land in acc before dividing it.
        if (!div_busy && !sqrt_busy && !acc_pending) begin
          div_start = 1'b1;
          state_next = ST_SQRT;
        end
      end
      ST_MAG_SQ_RE: state_next = ST_MAG_SQ_IM;
      ST_MAG_SQ_IM: state_next = ST_SQRT;
      ST_SQRT: begin
        // Start only once the last product or quotient has landed in acc.
        if (!div_busy && !sqrt_busy && !quot_pending && !acc_pending) begin
          sqrt_start = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sqrt_busy && !sqrt_start && !out_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      sum_real     <= '0;
      sum_imag     <= '0;
      acc          <= '0;
      out_valid    <= 1'b0;
      acc_pending  <= 1'b0;
      quot_pending <= 1'b0;
    end else begin
      acc_pending <= (state == ST_DEV_RE) || (state == ST_DEV_IM) ||
                     (state == ST_MAG_SQ_RE) || (state == ST_MAG_SQ_IM);
      if (state != ST_IDLE) begin
        sq <= mul_abs * mul_abs;
      end
      if (quot_pending && !div_busy) begin
        acc <= div_quot;
      end else if (acc_pending) begin
        acc <= acc + AccW'(sq);
      end
      if (in_xfer) begin
        if (closing) begin
          fill_count <= '0;
          sum_real   <= '0;
          sum_imag   <= '0;
          n          <= fill_inc;
          acc        <= '0;
          if (mode == MODE_VALUE || mode == MODE_ALT) begin
            out_valid <= 1'b1;
            value_re  <= sample_re;
            value_im  <= sample_im;
          end
        end else begin
          fill_count <= fill_inc;
          sum_real   <= sum_real + SW'(sample_re);
          sum_imag   <= sum_imag + SW'(sample_im);
        end
        mean_re <= sum_real + SW'(sample_re);
        mean_im <= sum_imag + SW'(sample_im);
      end
      if (state == ST_MEAN_RE && !div_busy) begin
        mean_re <= SW'(div_quot);
      end
      if (state == ST_MEAN_IM && !div_busy) begin
        mean_im <= SW'(div_quot);
      end
      if (state == ST_MEAN_IM) begin
        rd_idx <= '0;
      end else if (state == ST_DEV_IM) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (div_start && (state == ST_DEV_DIV)) begin
        quot_pending <= 1'b1;
      end else if (!div_busy) begin
        quot_pending <= 1'b0;
      end
      if (state == ST_DONE && !sqrt_busy && !sqrt_start && !out_valid) begin
        out_valid <= 1'b1;
        value_re  <= (root > RW'(SatMax)) ? SatMax : root[SAMPLE_WIDTH-1:0];
        value_im  <= '0;
      end
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_xfer |-> state == ST_IDLE);
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value_re)) else $error("result lost");
  assert property (@(posedge clk) disable iff (rst) fill_count <= CW'(MAX_WINDOW))
    else $error("fill count overrun");
  assert property (@(posedge clk) disable iff (rst) !(div_busy && sqrt_start))
    else $error("sqrt started during divide");
endmodule

// ----- hw/rtl/wss_ram.sv -----
// Generic single-port RAM with registered read.
module wss_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/wss_divider.sv -----
// Restoring divider, one quotient bit per cycle, truncating toward zero.
module wss_divider #(
  parameter int NumWidth = 64,
  parameter int DenWidth = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                num_neg,
  input  logic [NumWidth-1:0] num_mag,
  input  logic [DenWidth-1:0] den,
  output logic                busy,
  output logic [NumWidth-1:0] quot
);
  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] q;
  logic [DenWidth:0]   rem;
  logic [DenWidth-1:0] dreg;
  logic [CntWidth-1:0] cnt;
  logic                neg;
  logic [DenWidth:0]   trial;
  logic [DenWidth:0]   diff;

  assign trial = {rem[DenWidth-1:0], q[NumWidth-1]};
  assign diff  = trial - {1'b0, dreg};
  assign quot  = neg ? (~q + NumWidth'(1)) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntWidth'(NumWidth);
      q    <= num_mag;
      rem  <= '0;
      dreg <= den;
      neg  <= num_neg;
    end else if (busy) begin
      if (!diff[DenWidth]) begin
        rem <= diff;
        q   <= {q[NumWidth-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NumWidth-2:0], 1'b0};
      end
      cnt <= cnt - CntWidth'(1);
      if (cnt == CntWidth'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

// ----- hw/rtl/wss_sqrt.sv -----
// Integer square root, two radicand bits per cycle.
module wss_sqrt #(
  parameter int InWidth = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [InWidth-1:0]   radicand,
  output logic                 busy,
  output logic [InWidth/2-1:0] root
);
  localparam int Half     = InWidth / 2;
  localparam int CntWidth = $clog2(Half + 1);

  logic [InWidth-1:0]  x;
  logic [Half+1:0]     rem;
  logic [CntWidth-1:0] cnt;
  logic [Half+1:0]     trial;
  logic [Half+1:0]     test;

  assign trial = {rem[Half-1:0], x[InWidth-1:InWidth-2]};
  assign test  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntWidth'(Half);
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x <= {x[InWidth-3:0], 2'b00};
      if (trial >= test) begin
        rem  <= trial - test;
        root <= {root[Half-2:0], 1'b1};
      end else begin
        rem  <= trial;
        root <= {root[Half-2:0], 1'b0};
      end
      cnt <= cnt - CntWidth'(1);
      if (cnt == CntWidth'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule
